>>> src/fcc_pkg.sv
// Shared constants, codes and controller/datapath interface types of the chain checker.
package fcc_pkg;

  localparam int unsigned MAX_PAGES  = 4096;
  localparam int unsigned ADDR_W     = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned LINK_W     = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned PAGES_W    = 13;
  localparam int unsigned MARKER_W   = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST  = SHIFT_W'(9);
  localparam logic [PAGES_W-1:0] TABLE_PAGES_RST = '0;
  localparam logic [LINK_W-1:0]  FREE_LINK       = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_CHECK = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_OOB   = 3'd1,
    ST_LEN   = 3'd2,
    ST_UNREF = 3'd3,
    ST_STEP  = 3'd4
  } status_t;

  typedef enum logic {
    REG_PAGE_SHIFT  = 1'b0,
    REG_TABLE_PAGES = 1'b1
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic init;
    logic visit;
    logic advance;
    logic sweep_clr;
    logic sweep_step;
  } fcc_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic zero_len;
    logic unknown;
    logic oob;
    logic step_lim;
    logic match;
    logic last;
    logic sweep_done;
    logic hit;
  } fcc_sts_t;

endpackage

>>> src/fcc_datapath.sv
// Datapath of the chain checker: link table, unreferenced map, walk and sweep registers.
module fcc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [fcc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [fcc_pkg::ADDR_W-1:0]        load_index,
  input  logic [fcc_pkg::LINK_W-1:0]        load_value,
  input  logic [fcc_pkg::LINK_W-1:0]        start_page,
  input  logic [fcc_pkg::LINK_W-1:0]        byte_count,
  input  logic [fcc_pkg::MARKER_W-1:0]      end_marker,
  input  fcc_pkg::fcc_cmd_t                 cmd,
  output fcc_pkg::fcc_sts_t                 sts
);

  logic [fcc_pkg::LINK_W-1:0]   link_mem [fcc_pkg::MAX_PAGES];
  logic                         unref_mem [fcc_pkg::MAX_PAGES];

  logic [fcc_pkg::SHIFT_W-1:0]  page_shift_r;
  logic [fcc_pkg::PAGES_W-1:0]  table_pages_r;
  logic [fcc_pkg::CNT_W-1:0]    tp;

  logic [fcc_pkg::LINK_W-1:0]   cur_r;
  logic [fcc_pkg::LINK_W-1:0]   count_r;
  logic [fcc_pkg::MARKER_W-1:0] expect_r;
  logic [fcc_pkg::LINK_W-1:0]   remaining_r;
  logic [fcc_pkg::LINK_W-1:0]   remaining_nxt;
  logic [fcc_pkg::CNT_W-1:0]    steps_r;
  logic [fcc_pkg::CNT_W-1:0]    ptr_r;
  logic                         pend_r;
  logic                         hit_r;

  logic [fcc_pkg::LINK_W-1:0]   link_rd_r;
  logic                         unref_rd_r;
  logic [fcc_pkg::LINK_W-1:0]   expect_ext;
  logic [fcc_pkg::LINK_W-1:0]   count_m1;

  logic                         rd_en;
  logic [fcc_pkg::ADDR_W-1:0]   rd_addr;
  logic                         ptr_live;
  logic                         uw_en;
  logic [fcc_pkg::ADDR_W-1:0]   uw_addr;
  logic                         uw_data;

  // Effective table size, clipped to the table depth.
  assign tp = (table_pages_r > fcc_pkg::PAGES_W'(fcc_pkg::MAX_PAGES))
              ? fcc_pkg::CNT_W'(fcc_pkg::MAX_PAGES) : fcc_pkg::CNT_W'(table_pages_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r  <= fcc_pkg::PAGE_SHIFT_RST;
      table_pages_r <= fcc_pkg::TABLE_PAGES_RST;
    end else if (cfg_we) begin
      unique case (fcc_pkg::cfg_reg_t'(cfg_index))
        fcc_pkg::REG_PAGE_SHIFT:  page_shift_r  <= cfg_wdata[fcc_pkg::SHIFT_W-1:0];
        fcc_pkg::REG_TABLE_PAGES: table_pages_r <= cfg_wdata[fcc_pkg::PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  assign expect_ext    = {{(fcc_pkg::LINK_W-fcc_pkg::MARKER_W){expect_r[fcc_pkg::MARKER_W-1]}},
                          expect_r};
  assign count_m1      = count_r - fcc_pkg::LINK_W'(1);
  assign remaining_nxt = (count_m1 >> page_shift_r) + fcc_pkg::LINK_W'(1);

  assign ptr_live = (ptr_r < tp);
  assign rd_en    = cmd.visit | (cmd.sweep_step & ptr_live);
  assign rd_addr  = cmd.visit ? cur_r[fcc_pkg::ADDR_W-1:0] : ptr_r[fcc_pkg::ADDR_W-1:0];

  assign uw_en   = cmd.load_wr | cmd.visit;
  assign uw_addr = cmd.load_wr ? load_index : cur_r[fcc_pkg::ADDR_W-1:0];
  assign uw_data = cmd.load_wr;

  // Memories: one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      link_mem[load_index] <= load_value;
    end
    if (uw_en) begin
      unref_mem[uw_addr] <= uw_data;
    end
    if (rd_en) begin
      link_rd_r  <= link_mem[rd_addr];
      unref_rd_r <= unref_mem[rd_addr];
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r    <= start_page;
      count_r  <= byte_count;
      expect_r <= end_marker;
    end
    if (cmd.init) begin
      remaining_r <= remaining_nxt;
    end else if (cmd.advance) begin
      remaining_r <= remaining_r - fcc_pkg::LINK_W'(1);
      cur_r       <= link_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.init) begin
        steps_r <= '0;
      end else if (cmd.visit) begin
        steps_r <= steps_r + fcc_pkg::CNT_W'(1);
      end
      if (cmd.sweep_clr) begin
        ptr_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (cmd.sweep_step) begin
        pend_r <= ptr_live;
        if (ptr_live) begin
          ptr_r <= ptr_r + fcc_pkg::CNT_W'(1);
        end
        if (pend_r && unref_rd_r && (link_rd_r != fcc_pkg::FREE_LINK)) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  assign sts.zero_len   = (count_r == '0);
  assign sts.unknown    = count_r[fcc_pkg::LINK_W-1];
  assign sts.oob        = cur_r[fcc_pkg::LINK_W-1] |
                          (cur_r[fcc_pkg::LINK_W-2:0] >= (fcc_pkg::LINK_W-1)'(tp));
  assign sts.step_lim   = (steps_r >= tp);
  assign sts.match      = (link_rd_r == expect_ext);
  assign sts.last       = (remaining_r == fcc_pkg::LINK_W'(1));
  assign sts.sweep_done = !ptr_live && !pend_r;
  assign sts.hit        = hit_r;

  a_visit_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.visit |-> (!sts.oob && (steps_r < tp)))
    else $error("page visited out of bounds or past the step limit");

  a_visit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.visit && !cmd.init) |=> (steps_r == $past(steps_r) + fcc_pkg::CNT_W'(1)))
    else $error("step counter did not follow a visit");

endmodule

>>> src/fcc_ctrl.sv
// Controller state machine of the chain checker and its result register.
module fcc_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fcc_pkg::ACTION_W-1:0]     action,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fcc_pkg::STATUS_W-1:0]     status,
  output fcc_pkg::fcc_cmd_t                cmd,
  input  fcc_pkg::fcc_sts_t                sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_STEP,
    S_EVAL,
    S_CHK,
    S_RESULT
  } state_t;

  state_t            state_r;
  fcc_pkg::status_t  res_r;
  fcc_pkg::status_t  out_status_r;
  logic              out_valid_r;
  logic              accept;
  logic              slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign status     = out_status_r;

  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.load_wr    = accept && (action == fcc_pkg::ACT_LOAD);
    cmd.sweep_clr  = accept && (action == fcc_pkg::ACT_CHECK);
    cmd.init       = (state_r == S_START);
    cmd.visit      = (state_r == S_STEP) && !sts.oob && !sts.step_lim;
    cmd.sweep_step = (state_r == S_CHK);
    cmd.advance    = (state_r == S_EVAL) &&
                     (sts.unknown ? !sts.match : (!sts.last && !sts.match));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_r        <= fcc_pkg::ST_OK;
      out_status_r <= fcc_pkg::ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      // In the result state the output register is refilled instead of emptied.
      if (out_valid_r && out_tready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (action)
              fcc_pkg::ACT_MARK:  state_r <= S_START;
              fcc_pkg::ACT_CHECK: state_r <= S_CHK;
              default: begin
                res_r   <= fcc_pkg::ST_OK;
                state_r <= S_RESULT;
              end
            endcase
          end
        end
        S_START: begin
          if (sts.zero_len) begin
            res_r   <= fcc_pkg::ST_OK;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (sts.oob) begin
            res_r   <= fcc_pkg::ST_OOB;
            state_r <= S_RESULT;
          end else if (sts.step_lim) begin
            res_r   <= fcc_pkg::ST_STEP;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (sts.unknown) begin
            if (sts.match) begin
              res_r   <= fcc_pkg::ST_OK;
              state_r <= S_RESULT;
            end else begin
              state_r <= S_STEP;
            end
          end else if (sts.last) begin
            res_r   <= sts.match ? fcc_pkg::ST_OK : fcc_pkg::ST_LEN;
            state_r <= S_RESULT;
          end else if (sts.match) begin
            res_r   <= fcc_pkg::ST_LEN;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_CHK: begin
          if (sts.sweep_done) begin
            res_r   <= sts.hit ? fcc_pkg::ST_UNREF : fcc_pkg::ST_OK;
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_eval_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> ($past(state_r) == S_STEP))
    else $error("evaluation without a preceding table read");

  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && slot_free) |=> (out_valid_r && out_status_r == $past(res_r)))
    else $error("finished result not placed in the output register");

endmodule

>>> src/fat_chain_checker.sv
// Top level of the chain checker: port packing, controller and datapath.
//
// The block keeps a 4096-entry table of next-page links and a map of pages not yet
// referenced. Items arrive on the in_ stream: in_tuser carries the action (load an
// entry, mark a chain, check for unreferenced pages) and in_tdata the operands. Every
// item produces exactly one result item on the out_ stream, a 3-bit status code.
// The two configuration registers (page shift and table size) are written through
// the cfg_ port; the user must do so while the block is idle, which it does not check.
// A load goes from acceptance straight to the result state. A mark walks the chain
// one page at a time, each step being one registered read of the link table followed
// by an evaluation state; a walk stopped by a bounds or step-limit error ends in the
// step state without a read. A check sweeps the table at one entry per cycle through
// the same read port. The block works on one item at a time; in_tready is high only
// while the controller is idle. A result waits in an output register, so the next
// item is taken while it is pending; when the receiver stalls and the next result is
// also ready, the controller holds it and takes no further item until the register
// frees. Reset (rst_n low at a clock edge) returns the controller to idle, empties the
// output register and restores the page shift to 9 and the table size to 0. The
// table contents are not cleared: entries must be loaded before they are used.
module fat_chain_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // load_index[11:0], load_value[43:12], start_page[75:44], byte_count[107:76],
  // end_marker[110:108], zero fill above
  input  logic [fcc_pkg::IN_DATA_W-1:0]      in_tdata,
  // action[1:0]
  input  logic [fcc_pkg::ACTION_W-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[2:0], zero fill above
  output logic [fcc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [fcc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  fcc_pkg::fcc_cmd_t                  cmd;
  fcc_pkg::fcc_sts_t                  sts;
  logic [fcc_pkg::STATUS_W-1:0]       status;

  assign out_tdata = {{(fcc_pkg::OUT_DATA_W-fcc_pkg::STATUS_W){1'b0}}, status};

  fcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .action     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd),
    .sts        (sts)
  );

  fcc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .load_index (in_tdata[11:0]),
    .load_value (in_tdata[43:12]),
    .start_page (in_tdata[75:44]),
    .byte_count (in_tdata[107:76]),
    .end_marker (in_tdata[110:108]),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
